### hw/rtl/ssi_pkg.sv
// types, constants and step functions of the sphere-sphere intersection pipeline
package ssi_pkg;

	localparam int SQA_STEPS = 34;
	localparam int DIV_STEPS = 32;
	localparam int SQB_STEPS = 31;
	localparam int NORM_BITS = 30;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_POINT  = 2'd1,
		KIND_CIRCLE = 2'd2
	} kind_t;

	typedef struct packed {
		logic [2:0][31:0] a;
		logic [2:0]       dneg;
		logic [2:0][32:0] dm;
		logic [30:0]      ra;
		logic [31:0]      sum;
		logic [30:0]      diff;
		logic             ragb;
		logic [62:0]      s;
		logic [61:0]      rr;
		logic [65:0]      d2;
	} geo_t;

	typedef struct packed {
		geo_t        g;
		logic [36:0] rem;
		logic [33:0] root;
	} sqa_t;

	typedef struct packed {
		logic [2:0][31:0] a;
		logic [2:0]       dneg;
		kind_t            kind;
		logic             aneg;
		logic [30:0]      ra;
		logic [61:0]      rr;
		logic [34:0]      dn;
		logic [34:0]      dt;
		logic [2:0][62:0] nn;
		logic [66:0]      nt;
		logic [2:0][35:0] rn;
		logic [35:0]      rt;
		logic [2:0][30:0] qn;
		logic [31:0]      qt;
	} dv_t;

	typedef struct packed {
		logic [2:0][31:0] a;
		logic [2:0]       dneg;
		kind_t            kind;
		logic             aneg;
		logic [2:0][30:0] qn;
		logic [31:0]      amag;
		logic [61:0]      rr;
		logic [63:0]      xx;
	} p4_t;

	typedef struct packed {
		logic [2:0][31:0] a;
		logic [2:0]       dneg;
		kind_t            kind;
		logic             aneg;
		logic [2:0][30:0] qn;
		logic [2:0][62:0] prod;
		logic [61:0]      rad;
	} p5_t;

	typedef struct packed {
		kind_t            kind;
		logic [2:0][31:0] pt;
		logic [2:0][31:0] nrm;
		logic [61:0]      rad;
		logic [36:0]      rem;
		logic [33:0]      root;
	} sqb_t;

	typedef struct packed {
		logic [36:0] rem;
		logic [33:0] root;
	} sqrt_step_t;

	typedef struct packed {
		logic [35:0] rem;
		logic        q;
	} div_step_t;

	// one result bit of a restoring square root
	function automatic sqrt_step_t sqrt_step(input logic [36:0] rem, input logic [33:0] root,
		input logic [1:0] pair);
		logic [38:0] r2;
		logic [38:0] trial;
		sqrt_step_t  o;
		r2 = {rem, pair};
		trial = {3'b000, root, 2'b01};
		if (r2 >= trial) begin
			o.rem = 37'(r2 - trial);
			o.root = {root[32:0], 1'b1};
		end else begin
			o.rem = r2[36:0];
			o.root = {root[32:0], 1'b0};
		end
		return o;
	endfunction

	// one quotient bit of a restoring division
	function automatic div_step_t div_step(input logic [35:0] rem, input logic [34:0] den,
		input logic b);
		logic [35:0] r;
		div_step_t   o;
		r = {rem[34:0], b};
		if (r >= {1'b0, den}) begin
			o.rem = r - {1'b0, den};
			o.q = 1'b1;
		end else begin
			o.rem = r;
			o.q = 1'b0;
		end
		return o;
	endfunction

endpackage

### hw/rtl/sphere_sphere_intersect_top.sv
// sphere-sphere intersection classifier, fully pipelined
// One sphere pair is accepted every cycle unless the output stalls; the depth is set by the
// bit-serial stages: a 34-step square root for the centre distance, a 32-step divider bank for
// the normal and circle offset, and a 31-step square root for the circle radius. A stall on the
// output holds the whole pipeline, and input is taken whenever the last stage is empty or is being
// drained. touch_tolerance is written through cfg_wr_en and cfg_wr_data; the user must write it
// only while no transaction is in flight (the block does not enforce this). Reset sets it to 1.
module sphere_sphere_intersect_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [15:0]  cfg_wr_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// centre_a_x, centre_a_y, centre_a_z, radius_a, centre_b_x, centre_b_y, centre_b_z, radius_b
	input  logic [255:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// point_x, point_y, point_z, normal_x, normal_y, normal_z, circle_radius
	output logic [223:0] m_axis_tdata,
	// kind
	output logic [1:0]   m_axis_tuser
);

	logic [15:0] tol_q;
	logic        en;

	ssi_pkg::geo_t in_s1;
	ssi_pkg::geo_t geo_s2;
	logic [2:0][65:0] sq_s2;
	logic vld_s1, vld_s2;

	ssi_pkg::sqa_t sqa_s [0:ssi_pkg::SQA_STEPS];
	logic [ssi_pkg::SQA_STEPS:0] sqa_vld;
	ssi_pkg::dv_t dv_s [0:ssi_pkg::DIV_STEPS];
	logic [ssi_pkg::DIV_STEPS:0] dv_vld;
	ssi_pkg::p4_t p4_s;
	ssi_pkg::p5_t p5_s;
	logic vld_p4, vld_p5;
	ssi_pkg::sqb_t sqb_s [0:ssi_pkg::SQB_STEPS];
	logic [ssi_pkg::SQB_STEPS:0] sqb_vld;

	assign en = !sqb_vld[ssi_pkg::SQB_STEPS] || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= 16'd1;
		end else if (cfg_wr_en) begin
			tol_q <= cfg_wr_data;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			sqa_vld <= '0;
			dv_vld <= '0;
			vld_p4 <= 1'b0;
			vld_p5 <= 1'b0;
			sqb_vld <= '0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			sqa_vld <= {sqa_vld[ssi_pkg::SQA_STEPS-1:0], vld_s2};
			dv_vld <= {dv_vld[ssi_pkg::DIV_STEPS-1:0], sqa_vld[ssi_pkg::SQA_STEPS]};
			vld_p4 <= dv_vld[ssi_pkg::DIV_STEPS];
			vld_p5 <= vld_p4;
			sqb_vld <= {sqb_vld[ssi_pkg::SQB_STEPS-1:0], vld_p5};
		end
	end

	// stage 1: differences, magnitudes, radius sum and difference
	logic [2:0][31:0] ca, cb;
	logic [30:0]      ra_in, rb_in;
	logic [2:0][32:0] dsg;
	always_comb begin
		ca[0] = s_axis_tdata[31:0];
		ca[1] = s_axis_tdata[63:32];
		ca[2] = s_axis_tdata[95:64];
		ra_in = s_axis_tdata[126:96];
		cb[0] = s_axis_tdata[158:127];
		cb[1] = s_axis_tdata[190:159];
		cb[2] = s_axis_tdata[222:191];
		rb_in = s_axis_tdata[253:223];
		for (int i = 0; i < 3; i++) begin
			dsg[i] = {cb[i][31], cb[i]} - {ca[i][31], ca[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				in_s1.a[i] <= ca[i];
				in_s1.dneg[i] <= dsg[i][32];
				in_s1.dm[i] <= dsg[i][32] ? 33'(33'd0 - dsg[i]) : dsg[i];
			end
			in_s1.ra <= ra_in;
			in_s1.sum <= {1'b0, ra_in} + {1'b0, rb_in};
			in_s1.diff <= (ra_in >= rb_in) ? ra_in - rb_in : rb_in - ra_in;
			in_s1.ragb <= ra_in >= rb_in;
			in_s1.s <= '0;
			in_s1.rr <= '0;
			in_s1.d2 <= '0;
		end
	end

	// stage 2: squares and products
	ssi_pkg::geo_t geo_n;
	always_comb begin
		geo_n = in_s1;
		geo_n.s = 63'(in_s1.diff) * 63'(in_s1.sum);
		geo_n.rr = 62'(in_s1.ra) * 62'(in_s1.ra);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			geo_s2 <= geo_n;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= 66'(in_s1.dm[i]) * 66'(in_s1.dm[i]);
			end
		end
	end

	// stage 3: squared distance
	ssi_pkg::geo_t geo_d2;
	always_comb begin
		geo_d2 = geo_s2;
		geo_d2.d2 = sq_s2[0] + sq_s2[1] + sq_s2[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s[0].g <= geo_d2;
			sqa_s[0].rem <= '0;
			sqa_s[0].root <= '0;
		end
	end

	// centre distance square root
	for (genvar j = 0; j < ssi_pkg::SQA_STEPS; j++) begin : g_sqa
		localparam int P = ssi_pkg::SQA_STEPS - 1 - j;
		logic [67:0] rad;
		ssi_pkg::sqrt_step_t st;
		assign rad = {2'b00, sqa_s[j].g.d2};
		assign st = ssi_pkg::sqrt_step(sqa_s[j].rem, sqa_s[j].root, rad[2*P+1 -: 2]);
		always_ff @(posedge clk) begin
			if (en) begin
				sqa_s[j+1].g <= sqa_s[j].g;
				sqa_s[j+1].rem <= st.rem;
				sqa_s[j+1].root <= st.root;
			end
		end
	end

	// classification and divider setup
	ssi_pkg::geo_t    gq;
	logic [33:0]      dst;
	logic [65:0]      dd;
	logic [66:0]      dd_x, s_x;
	logic             far, touch, nest;
	ssi_pkg::kind_t   kd;
	logic [66:0]      nt;
	logic             aneg;
	logic [2:0][62:0] nn;
	always_comb begin
		gq = sqa_s[ssi_pkg::SQA_STEPS].g;
		dst = sqa_s[ssi_pkg::SQA_STEPS].root;
		dd = gq.d2 - 66'(sqa_s[ssi_pkg::SQA_STEPS].rem);
		dd_x = {1'b0, dd};
		s_x = 67'(gq.s);
		far = (dst > {2'b00, gq.sum}) || (dst == 34'd0);
		touch = ({2'b00, gq.sum} - dst) < {18'd0, tol_q};
		nest = dst < {3'b000, gq.diff};
		priority if (far) begin
			kd = ssi_pkg::KIND_NONE;
		end else if (touch) begin
			kd = ssi_pkg::KIND_POINT;
		end else if (nest) begin
			kd = ssi_pkg::KIND_NONE;
		end else begin
			kd = ssi_pkg::KIND_CIRCLE;
		end
		aneg = 1'b0;
		priority if (gq.ragb) begin
			nt = dd_x + s_x;
		end else if (dd_x >= s_x) begin
			nt = dd_x - s_x;
		end else begin
			nt = s_x - dd_x;
			aneg = kd == ssi_pkg::KIND_CIRCLE;
		end
		for (int i = 0; i < 3; i++) begin
			nn[i] = {gq.dm[i], 30'd0} + 63'(dst[33:1]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].a <= gq.a;
			dv_s[0].dneg <= gq.dneg;
			dv_s[0].kind <= kd;
			dv_s[0].aneg <= aneg;
			dv_s[0].ra <= gq.ra;
			dv_s[0].rr <= gq.rr;
			dv_s[0].dn <= 35'(dst);
			dv_s[0].dt <= {dst, 1'b0};
			dv_s[0].nn <= nn;
			dv_s[0].nt <= nt;
			for (int i = 0; i < 3; i++) begin
				dv_s[0].rn[i] <= 36'(nn[i][62:31]);
			end
			dv_s[0].rt <= 36'(nt[66:32]);
			dv_s[0].qn <= '0;
			dv_s[0].qt <= '0;
		end
	end

	// normal and circle offset dividers
	for (genvar j = 0; j < ssi_pkg::DIV_STEPS; j++) begin : g_div
		localparam int B = ssi_pkg::DIV_STEPS - 1 - j;
		ssi_pkg::div_step_t stt;
		ssi_pkg::div_step_t stn [3];
		ssi_pkg::dv_t       nx;
		assign stt = ssi_pkg::div_step(dv_s[j].rt, dv_s[j].dt, dv_s[j].nt[B]);
		for (genvar k = 0; k < 3; k++) begin : g_n
			assign stn[k] = ssi_pkg::div_step(dv_s[j].rn[k], dv_s[j].dn, dv_s[j].nn[k][B]);
		end
		always_comb begin
			nx = dv_s[j];
			nx.rt = stt.rem;
			nx.qt = {dv_s[j].qt[30:0], stt.q};
			if (j >= 1) begin
				for (int k = 0; k < 3; k++) begin
					nx.rn[k] = stn[k].rem;
					nx.qn[k] = {dv_s[j].qn[k][29:0], stn[k].q};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j+1] <= nx;
			end
		end
	end

	// offset magnitude and its square
	ssi_pkg::dv_t dq;
	logic [31:0]  amag;
	assign dq = dv_s[ssi_pkg::DIV_STEPS];
	assign amag = (dq.kind == ssi_pkg::KIND_POINT) ? {1'b0, dq.ra} : dq.qt;

	always_ff @(posedge clk) begin
		if (en) begin
			p4_s.a <= dq.a;
			p4_s.dneg <= dq.dneg;
			p4_s.kind <= dq.kind;
			p4_s.aneg <= dq.aneg;
			p4_s.qn <= dq.qn;
			p4_s.amag <= amag;
			p4_s.rr <= dq.rr;
			p4_s.xx <= 64'(dq.qt) * 64'(dq.qt);
		end
	end

	// point offset products and circle radicand
	always_ff @(posedge clk) begin
		if (en) begin
			p5_s.a <= p4_s.a;
			p5_s.dneg <= p4_s.dneg;
			p5_s.kind <= p4_s.kind;
			p5_s.aneg <= p4_s.aneg;
			p5_s.qn <= p4_s.qn;
			for (int i = 0; i < 3; i++) begin
				p5_s.prod[i] <= 63'(p4_s.qn[i]) * 63'(p4_s.amag);
			end
			if (p4_s.kind == ssi_pkg::KIND_CIRCLE && 64'(p4_s.rr) > p4_s.xx) begin
				p5_s.rad <= 62'(64'(p4_s.rr) - p4_s.xx);
			end else begin
				p5_s.rad <= '0;
			end
		end
	end

	// rounded offsets, saturated points, signed normals
	logic [2:0][32:0]        off;
	logic signed [2:0][34:0] psum;
	logic [2:0][31:0]        pt, nrm;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			off[i] = 33'((64'(p5_s.prod[i]) + 64'(1 << (ssi_pkg::NORM_BITS - 1)))
				>> ssi_pkg::NORM_BITS);
			if (p5_s.dneg[i] ^ p5_s.aneg) begin
				psum[i] = {{3{p5_s.a[i][31]}}, p5_s.a[i]} - {2'b00, off[i]};
			end else begin
				psum[i] = {{3{p5_s.a[i][31]}}, p5_s.a[i]} + {2'b00, off[i]};
			end
			if (p5_s.kind == ssi_pkg::KIND_NONE) begin
				pt[i] = '0;
			end else if (!psum[i][34] && psum[i][33:31] != 3'b000) begin
				pt[i] = 32'h7fff_ffff;
			end else if (psum[i][34] && psum[i][33:31] != 3'b111) begin
				pt[i] = 32'h8000_0000;
			end else begin
				pt[i] = psum[i][31:0];
			end
			if (p5_s.kind != ssi_pkg::KIND_CIRCLE) begin
				nrm[i] = '0;
			end else if (p5_s.dneg[i]) begin
				nrm[i] = 32'd0 - {1'b0, p5_s.qn[i]};
			end else begin
				nrm[i] = {1'b0, p5_s.qn[i]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqb_s[0].kind <= p5_s.kind;
			sqb_s[0].pt <= pt;
			sqb_s[0].nrm <= nrm;
			sqb_s[0].rad <= p5_s.rad;
			sqb_s[0].rem <= '0;
			sqb_s[0].root <= '0;
		end
	end

	// circle radius square root
	for (genvar j = 0; j < ssi_pkg::SQB_STEPS; j++) begin : g_sqb
		localparam int P = ssi_pkg::SQB_STEPS - 1 - j;
		ssi_pkg::sqrt_step_t st;
		ssi_pkg::sqb_t       nx;
		assign st = ssi_pkg::sqrt_step(sqb_s[j].rem, sqb_s[j].root, sqb_s[j].rad[2*P+1 -: 2]);
		always_comb begin
			nx = sqb_s[j];
			nx.rem = st.rem;
			nx.root = st.root;
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sqb_s[j+1] <= nx;
			end
		end
	end

	assign m_axis_tvalid = sqb_vld[ssi_pkg::SQB_STEPS];
	assign m_axis_tuser = sqb_s[ssi_pkg::SQB_STEPS].kind;
	assign m_axis_tdata = {1'b0, sqb_s[ssi_pkg::SQB_STEPS].root[30:0],
		sqb_s[ssi_pkg::SQB_STEPS].nrm[2], sqb_s[ssi_pkg::SQB_STEPS].nrm[1],
		sqb_s[ssi_pkg::SQB_STEPS].nrm[0], sqb_s[ssi_pkg::SQB_STEPS].pt[2],
		sqb_s[ssi_pkg::SQB_STEPS].pt[1], sqb_s[ssi_pkg::SQB_STEPS].pt[0]};

endmodule

### tb/sphere_sphere_intersect_top_test.sv
// testbench for the sphere-sphere intersection classifier: directed table, random pairs, scoreboard
module sphere_sphere_intersect_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] ax, ay, az;
		logic [30:0] ra;
		logic [31:0] bx, by, bz;
		logic [30:0] rb;
	} pair_t;

	typedef struct packed {
		ssi_pkg::kind_t kind;
		logic [31:0]    px, py, pz, nx, ny, nz;
		logic [30:0]    rad;
	} isect_t;

	typedef struct {
		pair_t  p;
		bit     typed;
		isect_t res;
	} dir_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_wr_en = 1'b0;
	logic [15:0]  cfg_wr_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [255:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [223:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;

	sphere_sphere_intersect_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	isect_t      isect_q[$];
	logic [15:0] tol_model = 16'd1;
	int          errors = 0;
	int          n_sent = 0;
	int          n_recv = 0;
	int          kind_cnt[3] = '{0, 0, 0};
	int          ready_pct = 100;
	int          holdoff_req = 0;
	int          hold_cnt = 0;
	int          gap_max = 6;
	int          burst_left = 0;
	bit          valid_hi = 0;

	function automatic logic [33:0] isqrt(input logic [127:0] v);
		logic [127:0] c;
		logic [33:0]  r;
		r = '0;
		for (int b = 33; b >= 0; b--) begin
			c = 128'(r) | (128'd1 << b);
			if (c * c <= v) r = c[33:0];
		end
		return r;
	endfunction

	function automatic isect_t predict_isect(input pair_t p);
		logic signed [63:0] a[3], d[3], nv[3], pv;
		logic [127:0]       m[3], d2, q, dd, s, num, amag, rr, xx, off, rad;
		logic [63:0]        dlen, sum, diff;
		logic [31:0]        pt[3];
		logic               aneg, neg;
		isect_t             r;
		r = '0;
		r.kind = ssi_pkg::KIND_NONE;
		a[0] = $signed(p.ax); a[1] = $signed(p.ay); a[2] = $signed(p.az);
		d[0] = $signed(p.bx) - a[0];
		d[1] = $signed(p.by) - a[1];
		d[2] = $signed(p.bz) - a[2];
		for (int i = 0; i < 3; i++) m[i] = d[i] < 0 ? 128'(-d[i]) : 128'(d[i]);
		d2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
		dlen = 64'(isqrt(d2));
		sum = 64'(p.ra) + 64'(p.rb);
		diff = p.ra >= p.rb ? 64'(p.ra) - 64'(p.rb) : 64'(p.rb) - 64'(p.ra);
		if (dlen > sum || dlen == 0) return r;
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << ssi_pkg::NORM_BITS) + 128'(dlen / 2)) / 128'(dlen);
			nv[i] = $signed(q[63:0]);
			if (d[i] < 0) nv[i] = -nv[i];
		end
		aneg = 1'b0;
		amag = '0;
		if (sum - dlen < 64'(tol_model)) begin
			r.kind = ssi_pkg::KIND_POINT;
			amag = 128'(p.ra);
		end else if (dlen < diff) begin
			return r;
		end else begin
			dd = 128'(dlen) * 128'(dlen);
			s = 128'(diff) * 128'(sum);
			if (p.ra >= p.rb) num = dd + s;
			else if (dd >= s) num = dd - s;
			else begin
				num = s - dd;
				aneg = 1'b1;
			end
			amag = num / (128'(dlen) * 2);
			rr = 128'(p.ra) * 128'(p.ra);
			xx = amag * amag;
			rad = rr > xx ? 128'(isqrt(rr - xx)) : '0;
			r.kind = ssi_pkg::KIND_CIRCLE;
			r.nx = nv[0][31:0]; r.ny = nv[1][31:0]; r.nz = nv[2][31:0];
			r.rad = rad[30:0];
		end
		for (int i = 0; i < 3; i++) begin
			q = nv[i] < 0 ? 128'(-nv[i]) : 128'(nv[i]);
			off = (q * amag + (128'd1 << (ssi_pkg::NORM_BITS - 1))) >> ssi_pkg::NORM_BITS;
			neg = (nv[i] < 0) != aneg;
			pv = neg ? a[i] - $signed(off[63:0]) : a[i] + $signed(off[63:0]);
			if (pv > 64'sd2147483647) pv = 64'sd2147483647;
			if (pv < -64'sd2147483648) pv = -64'sd2147483648;
			pt[i] = pv[31:0];
		end
		r.px = pt[0]; r.py = pt[1]; r.pz = pt[2];
		return r;
	endfunction

	function automatic logic [31:0] near_coord();
		logic [31:0] v;
		v = $urandom;
		return {{11{v[20]}}, v[20:0]};
	endfunction

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 3))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] pick_radius();
		case ($urandom_range(0, 2))
			0: return '0;
			1: return '1;
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic pair_t rand_pair();
		pair_t       p;
		int unsigned k, extra;
		logic [30:0] t;
		p.ax = near_coord(); p.ay = near_coord(); p.az = near_coord();
		p.bx = p.ax; p.by = p.ay; p.bz = p.az;
		p.ra = 31'($urandom_range(0, 1 << 19));
		p.rb = 31'($urandom_range(0, 1 << 19));
		case ($urandom_range(0, 9))
			0, 1: begin
				p = 254'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom});
			end
			2, 3, 4: begin
				p.bx = p.ax + 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
				p.by = p.ay + 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
				p.bz = p.az + 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
			end
			5, 6: begin
				k = $urandom_range(1, 1 << 20);
				extra = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 70000);
				case ($urandom_range(0, 2))
					0: p.bx = $urandom_range(0, 1) ? p.ax + k : p.ax - k;
					1: p.by = $urandom_range(0, 1) ? p.ay + k : p.ay - k;
					default: p.bz = $urandom_range(0, 1) ? p.az + k : p.az - k;
				endcase
				p.ra = 31'($urandom_range(0, k));
				p.rb = 31'(k + extra) - p.ra;
			end
			7: begin
				p.bx = p.ax + 32'($urandom_range(0, 2048)) - 32'd1024;
				p.ra = 31'($urandom_range(1 << 16, 1 << 20));
				p.rb = 31'($urandom_range(0, 1 << 12));
				if ($urandom_range(0, 1)) begin
					t = p.ra; p.ra = p.rb; p.rb = t;
				end
			end
			8: begin
				p.ra = pick_radius();
				p.rb = pick_radius();
			end
			default: begin
				p.ax = pick_extreme(); p.ay = pick_extreme(); p.az = pick_extreme();
				p.bx = pick_extreme(); p.by = pick_extreme(); p.bz = pick_extreme();
				p.ra = pick_radius(); p.rb = pick_radius();
			end
		endcase
		return p;
	endfunction

	task automatic send_pair(input pair_t p, input bit typed, input isect_t res);
		int gap;
		s_axis_tdata <= {2'b00, p.rb, p.bz, p.by, p.bx, p.ra, p.az, p.ay, p.ax};
		s_axis_tvalid <= 1'b1;
		valid_hi = 1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		isect_q.push_back(typed ? res : predict_isect(p));
		n_sent++;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				valid_hi = 0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic drain();
		if (valid_hi) s_axis_tvalid <= 1'b0;
		valid_hi = 0;
		while (isect_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [15:0] v);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tol_model = v;
	endtask

	task automatic random_phase(input int count, input int pct, input int gmax);
		ready_pct = pct;
		gap_max = gmax;
		for (int i = 0; i < count; i++) send_pair(rand_pair(), 0, '0);
	endtask

	// receiver stall pattern, with a long hold-off on request
	always @(posedge clk) begin
		if (holdoff_req > 0) begin
			hold_cnt = holdoff_req;
			holdoff_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
		end
	end

	always @(posedge clk) begin
		isect_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.kind = ssi_pkg::kind_t'(m_axis_tuser);
			got.px = m_axis_tdata[31:0];
			got.py = m_axis_tdata[63:32];
			got.pz = m_axis_tdata[95:64];
			got.nx = m_axis_tdata[127:96];
			got.ny = m_axis_tdata[159:128];
			got.nz = m_axis_tdata[191:160];
			got.rad = m_axis_tdata[222:192];
			n_recv++;
			if (m_axis_tuser < 3) kind_cnt[m_axis_tuser]++;
			if (isect_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result transaction: %p", got);
			end else begin
				want = isect_q.pop_front();
				if (got.kind !== want.kind || got.px !== want.px || got.py !== want.py ||
					got.pz !== want.pz || got.nx !== want.nx || got.ny !== want.ny ||
					got.nz !== want.nz || got.rad !== want.rad) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch on result %0d", n_recv);
						$display("  expected %p", want);
						$display("  actual   %p", got);
					end
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("timeout with %0d results outstanding", isect_q.size());
		$display("sphere_sphere_intersect_top_test: errors");
		$finish;
	end

	initial begin
		dir_row_t dir_tab[$];
		dir_row_t row;
		isect_t   zero_res;
		int       wait_cnt;
		zero_res = '0;
		zero_res.kind = ssi_pkg::KIND_NONE;

		// coincident centres, zero radii
		row.p = '0; row.typed = 1; row.res = zero_res; dir_tab.push_back(row);
		// far apart
		row.p = '0; row.p.bx = 32'h0001_0000; dir_tab.push_back(row);
		// every coordinate at its extreme, radii full scale
		row.p = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff};
		dir_tab.push_back(row);
		// nested spheres
		row.p = '0; row.p.ra = 31'h000a_0000; row.p.bx = 32'h0001_0000; row.p.rb = 31'h0001_0000;
		dir_tab.push_back(row);
		// exact touch at one point
		row.p = '0; row.p.ra = 31'h0001_0000; row.p.bx = 32'h0002_0000; row.p.rb = 31'h0001_0000;
		row.res = zero_res; row.res.kind = ssi_pkg::KIND_POINT; row.res.px = 32'h0001_0000;
		dir_tab.push_back(row);
		row.typed = 0; row.res = '0;
		// circles in several directions
		row.p = '0; row.p.ra = 31'h0002_0000; row.p.bx = 32'h0002_0000; row.p.rb = 31'h0002_0000;
		dir_tab.push_back(row);
		row.p = '0; row.p.ra = 31'h0003_0000; row.p.by = 32'hfffd_0000; row.p.rb = 31'h0002_0000;
		dir_tab.push_back(row);
		row.p = {32'h0001_0000, 32'hffff_0000, 32'h0000_8000, 31'h0001_8000,
			32'h0002_0000, 32'h0000_0000, 32'hffff_8000, 31'h0002_0000};
		dir_tab.push_back(row);
		// smaller first radius, offset behind centre a
		row.p = '0; row.p.ra = 31'h0001_0000; row.p.bz = 32'h0000_8000; row.p.rb = 31'h0001_4000;
		dir_tab.push_back(row);
		// point saturates at the top of the range
		row.p = {32'h7fff_0000, 32'h0, 32'h0, 31'h1000_0000,
			32'h7ffe_0000, 32'h0, 32'h0, 31'h1000_8000};
		dir_tab.push_back(row);
		// point saturates at the bottom of the range
		row.p = {32'h8000_ffff, 32'h0, 32'h0, 31'h1000_0000,
			32'h8001_ffff, 32'h0, 32'h0, 31'h1000_8000};
		dir_tab.push_back(row);
		// large separation, large radii
		row.p = {32'hc000_0000, 32'h4000_0000, 32'h0, 31'h7fff_ffff,
			32'h4000_0000, 32'hc000_0000, 32'h1234_5678, 31'h7fff_fff0};
		dir_tab.push_back(row);
		// tangent within the default tolerance and just outside it
		row.p = '0; row.p.ra = 31'h0001_0000; row.p.bx = 32'h0003_0000; row.p.rb = 31'h0002_0000;
		dir_tab.push_back(row);
		row.p = '0; row.p.ra = 31'h0001_0000; row.p.bx = 32'h0003_0000; row.p.rb = 31'h0002_0001;
		dir_tab.push_back(row);
		// one radius zero
		row.p = '0; row.p.ra = 31'h0; row.p.bx = 32'h0001_0000; row.p.rb = 31'h0001_0000;
		dir_tab.push_back(row);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		ready_pct = 80;
		foreach (dir_tab[i]) send_pair(dir_tab[i].p, dir_tab[i].typed, dir_tab[i].res);
		random_phase(40, 80, 6);

		write_tolerance(16'd0);
		random_phase(140, 100, 0);
		write_tolerance(16'hffff);
		holdoff_req = 400;
		random_phase(140, 60, 4);
		write_tolerance(16'($urandom));
		random_phase(140, 30, 8);
		write_tolerance(16'd1);
		holdoff_req = 300;
		random_phase(140, 90, 3);

		drain();
		wait_cnt = 0;
		while (wait_cnt < 120) begin
			@(posedge clk);
			wait_cnt++;
		end
		if (isect_q.size() != 0) errors++;

		$display("%0d sphere pairs sent over five tolerance settings, %0d results checked",
			n_sent, n_recv);
		$display("results by kind: none %0d, point %0d, circle %0d",
			kind_cnt[0], kind_cnt[1], kind_cnt[2]);
		if (errors == 0) begin
			$display("sphere_sphere_intersect_top_test: clean");
		end else begin
			$display("%0d mismatches", errors);
			$display("sphere_sphere_intersect_top_test: errors");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/ssi_pkg.sv
hw/rtl/sphere_sphere_intersect_top.sv
tb/sphere_sphere_intersect_top_test.sv
